/* hdl/fat_chain_allocator_top_assert.svh */
// Assertion macros for the allocation table controller RTL.
// Needs signals named clock and reset in the module that uses them.
`ifndef FAT_CHAIN_ALLOCATOR_TOP_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FCA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/fca_pkg.sv */
// Package for the allocation table block: widths, codes, state type and
// the command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package fca_pkg;

   // Table size default and fixed field widths.
   localparam int NUM_BLOCKS_DEF = 1024;
   localparam int DS_W           = 10;
   localparam int BIU_W          = 11;
   localparam int CNT_W          = 11;
   localparam int IDX_W          = 10;
   localparam int FIRST_W        = 10;
   localparam int ENT_OUT_W      = 11;
   localparam int FREED_W        = 11;
   localparam int CSR_AW         = 3;
   localparam int CSR_DW         = 32;
   localparam int REQ_DW         = 24;
   localparam int RSP_DW         = 40;

   // Register reset values.
   localparam logic [DS_W-1:0]  DS_RESET  = 10'd3;
   localparam logic [BIU_W-1:0] BIU_RESET = 11'd1024;

   // Table entry codes.
   localparam int ENTRY_FREE     = 0;
   localparam int ENTRY_END      = -1;
   localparam int ENTRY_RESERVED = -2;

   typedef enum logic [1:0] {
      CMD_FORMAT = 2'd0,
      CMD_ALLOC  = 2'd1,
      CMD_FREE   = 2'd2,
      CMD_READ   = 2'd3
   } fca_cmd_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_NO_SPACE = 2'd1,
      STS_BAD_ARG  = 2'd2
   } fca_status_type;

   typedef enum logic {
      REG_DATA_START    = 1'b0,
      REG_BLOCKS_IN_USE = 1'b1
   } fca_reg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_FORMAT,
      ST_COUNT,
      ST_LINK,
      ST_LINK_END,
      ST_FREE_WALK,
      ST_READ_WAIT,
      ST_FINISH
   } fca_state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic           load;
      logic           fmt_init;
      logic           data_init;
      logic           scan_issue;
      logic           fmt_write;
      logic           count_step;
      logic           link_step;
      logic           end_write;
      logic           rd_start;
      logic           free_step;
      logic           entry_capture;
      logic           status_set;
      fca_status_type status_code;
      logic           res_load;
   } fca_ctrl_type;

   // Status from datapath to controller.
   typedef struct packed {
      fca_cmd_type cmd;
      logic        count_zero;
      logic        start_is_data;
      logic        start_in_range;
      logic        scan_end;
      logic        fmt_last;
      logic        count_hit;
      logic        link_hit;
      logic        walk_more;
   } fca_stat_type;

endpackage

/* hdl/fca_datapath.sv */
// Datapath of the allocation table block: the table memory, scan and walk
// counters, result registers. Depends on fca_pkg; driven by fca_controller.
`timescale 1ns / 1ps

module fca_datapath #(
   parameter int NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  fca_pkg::fca_cmd_type             req_command,
   input  logic [fca_pkg::CNT_W-1:0]        req_block_count,
   input  logic [fca_pkg::IDX_W-1:0]        req_start_block,
   input  logic [fca_pkg::DS_W-1:0]         cfg_data_start,
   input  logic [fca_pkg::BIU_W-1:0]        cfg_blocks_in_use,
   input  fca_pkg::fca_ctrl_type            ctrl,
   output fca_pkg::fca_stat_type            stat,
   output fca_pkg::fca_status_type          rsp_status,
   output logic [fca_pkg::FIRST_W-1:0]      rsp_first_block,
   output logic signed [fca_pkg::ENT_OUT_W-1:0] rsp_entry_value,
   output logic [fca_pkg::FREED_W-1:0]      rsp_freed_count
);
   import fca_pkg::*;

   localparam int AW   = $clog2(NUM_BLOCKS);
   localparam int CW   = AW + 1;
   localparam int EW   = AW + 1;
   localparam int CMPW = (CW > BIU_W) ? CW : BIU_W;

   localparam logic signed [EW-1:0] ENT_FREE     = EW'(ENTRY_FREE);
   localparam logic signed [EW-1:0] ENT_END      = EW'(ENTRY_END);
   localparam logic signed [EW-1:0] ENT_RESERVED = EW'(ENTRY_RESERVED);
   localparam logic [CW-1:0]        SCAN_LAST    = CW'(NUM_BLOCKS - 1);
   localparam logic [CW-1:0]        SIZE_MAX     = CW'(NUM_BLOCKS);
   localparam logic [CMPW-1:0]      CMP_ONE      = CMPW'(1);

   // Item registers.
   fca_cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [IDX_W-1:0]      start_ff, start_in;
   logic [DS_W-1:0]       ds_ff, ds_in;
   logic [CW-1:0]         n_ff, n_in;

   // Scan and walk registers.
   logic [CW-1:0]         scan_ff, scan_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [AW-1:0]         pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]      avail_ff, avail_in;
   logic [CNT_W-1:0]      taken_ff, taken_in;
   logic                  have_first_ff, have_first_in;
   logic [AW-1:0]         first_ff, first_in;
   logic [AW-1:0]         prev_ff, prev_in;
   logic [AW-1:0]         blk_ff, blk_in;
   logic [FREED_W-1:0]    freed_ff, freed_in;
   logic signed [ENT_OUT_W-1:0] entry_ff, entry_in;
   fca_status_type        status_ff, status_in;

   // Output register.
   fca_status_type        out_status_ff;
   logic [FIRST_W-1:0]    out_first_ff;
   logic signed [ENT_OUT_W-1:0] out_entry_ff;
   logic [FREED_W-1:0]    out_freed_ff;

   // Table memory and its ports.
   logic [EW-1:0]         table_mem [NUM_BLOCKS];
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [EW-1:0]         wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [EW-1:0]         rd_q_ff;
   logic                  byp_vld_ff;
   logic [EW-1:0]         byp_data_ff;
   logic signed [EW-1:0]  rd_data;

   // Derived flags.
   logic                  pend_free;
   logic                  rd_is_data;
   logic                  ds_ge_n;
   logic                  fmt_reserved;
   logic                  link_write;

   // A read that hits the address written in the same cycle returns the new data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff     <= table_mem[rd_addr];
         byp_vld_ff  <= wr_en && (wr_addr == rd_addr);
         byp_data_ff <= wr_data;
      end
   end

   assign rd_data = signed'(byp_vld_ff ? byp_data_ff : rd_q_ff);

   // Comparisons against the data window [data_start, n).
   assign pend_free    = (rd_data == ENT_FREE);
   assign rd_is_data   = !rd_data[EW-1]
                         && (CMPW'(rd_data[AW-1:0]) >= CMPW'(ds_ff))
                         && (CMPW'(rd_data[AW-1:0]) <  CMPW'(n_ff));
   assign ds_ge_n      = CMPW'(ds_ff) >= CMPW'(n_ff);
   assign fmt_reserved = CMPW'(scan_ff) < CMPW'(ds_ff);
   assign link_write   = ctrl.link_step && pend_vld_ff && pend_free && have_first_ff;

   // Status toward the controller.
   always_comb begin
      stat.cmd            = cmd_ff;
      stat.count_zero     = (count_ff == '0);
      stat.start_in_range = CMPW'(start_ff) < CMPW'(n_ff);
      stat.start_is_data  = (CMPW'(start_ff) >= CMPW'(ds_ff)) && stat.start_in_range;
      stat.scan_end       = CMPW'(scan_ff) >= CMPW'(n_ff);
      stat.fmt_last       = (scan_ff == SCAN_LAST);
      stat.count_hit      = pend_vld_ff && pend_free && ((avail_ff + CNT_W'(1)) == count_ff);
      stat.link_hit       = pend_vld_ff && pend_free && ((taken_ff + CNT_W'(1)) == count_ff);
      stat.walk_more      = rd_is_data
                            && ((CMPW'(freed_ff) + CMP_ONE) < CMPW'(n_ff));
   end

   // Memory port selection; the controller issues one writer per cycle.
   always_comb begin
      wr_en   = ctrl.fmt_write || link_write || ctrl.end_write || ctrl.free_step;
      wr_addr = blk_ff;
      wr_data = ENT_FREE;
      if (ctrl.fmt_write) begin
         wr_addr = scan_ff[AW-1:0];
         wr_data = fmt_reserved ? ENT_RESERVED : ENT_FREE;
      end else if (link_write) begin
         wr_addr = prev_ff;
         wr_data = {1'b0, pend_idx_ff};
      end else if (ctrl.end_write) begin
         wr_addr = prev_ff;
         wr_data = ENT_END;
      end

      rd_en   = ctrl.scan_issue || ctrl.rd_start || ctrl.free_step;
      rd_addr = scan_ff[AW-1:0];
      if (ctrl.rd_start) begin
         rd_addr = AW'(start_ff);
      end else if (ctrl.free_step) begin
         rd_addr = rd_data[AW-1:0];
      end
   end

   // Next values of the working registers.
   always_comb begin
      cmd_in        = cmd_ff;
      count_in      = count_ff;
      start_in      = start_ff;
      ds_in         = ds_ff;
      n_in          = n_ff;
      scan_in       = scan_ff;
      pend_vld_in   = 1'b0;
      pend_idx_in   = pend_idx_ff;
      avail_in      = avail_ff;
      taken_in      = taken_ff;
      have_first_in = have_first_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      blk_in        = blk_ff;
      freed_in      = freed_ff;
      entry_in      = entry_ff;
      status_in     = status_ff;

      // Latch the item and the configuration it runs under.
      if (ctrl.load) begin
         cmd_in    = req_command;
         count_in  = req_block_count;
         start_in  = req_start_block;
         ds_in     = cfg_data_start;
         if (int'(cfg_blocks_in_use) < NUM_BLOCKS) begin
            n_in = CW'(cfg_blocks_in_use);
         end else begin
            n_in = SIZE_MAX;
         end
         first_in  = '0;
         freed_in  = '0;
         entry_in  = '0;
         status_in = STS_OK;
      end

      if (ctrl.fmt_init) begin
         scan_in = '0;
      end
      if (ctrl.fmt_write) begin
         scan_in = scan_ff + CW'(1);
      end

      // First allocation pass counts free data blocks.
      if (ctrl.count_step && pend_vld_ff && pend_free) begin
         avail_in = avail_ff + CNT_W'(1);
      end

      // Second allocation pass links the free blocks it meets.
      if (ctrl.link_step && pend_vld_ff && pend_free) begin
         if (!have_first_ff) begin
            first_in      = pend_idx_ff;
            have_first_in = 1'b1;
         end
         prev_in  = pend_idx_ff;
         taken_in = taken_ff + CNT_W'(1);
      end

      // Both passes start at the first data block.
      if (ctrl.data_init) begin
         scan_in       = ds_ge_n ? n_ff : CW'(ds_ff);
         avail_in      = '0;
         taken_in      = '0;
         have_first_in = 1'b0;
      end

      if (ctrl.scan_issue) begin
         scan_in     = scan_ff + CW'(1);
         pend_vld_in = 1'b1;
         pend_idx_in = scan_ff[AW-1:0];
      end

      // Chain walk: release the current block and follow its link.
      if (ctrl.rd_start) begin
         blk_in = AW'(start_ff);
      end
      if (ctrl.free_step) begin
         blk_in   = rd_data[AW-1:0];
         freed_in = freed_ff + FREED_W'(1);
      end

      if (ctrl.entry_capture) begin
         entry_in = ENT_OUT_W'(rd_data);
      end
      if (ctrl.status_set) begin
         status_in = ctrl.status_code;
      end
   end

   // Control registers; ds_ff resets to the reset data start for the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff     <= '0;
         pend_vld_ff <= 1'b0;
         ds_ff       <= DS_RESET;
      end else begin
         scan_ff     <= scan_in;
         pend_vld_ff <= pend_vld_in;
         ds_ff       <= ds_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      count_ff      <= count_in;
      start_ff      <= start_in;
      n_ff          <= n_in;
      pend_idx_ff   <= pend_idx_in;
      avail_ff      <= avail_in;
      taken_ff      <= taken_in;
      have_first_ff <= have_first_in;
      first_ff      <= first_in;
      prev_ff       <= prev_in;
      blk_ff        <= blk_in;
      freed_ff      <= freed_in;
      entry_ff      <= entry_in;
      status_ff     <= status_in;
      if (ctrl.res_load) begin
         out_status_ff <= status_ff;
         out_first_ff  <= FIRST_W'(first_ff);
         out_entry_ff  <= entry_ff;
         out_freed_ff  <= freed_ff;
      end
   end

   assign rsp_status      = out_status_ff;
   assign rsp_first_block = out_first_ff;
   assign rsp_entry_value = out_entry_ff;
   assign rsp_freed_count = out_freed_ff;

endmodule

/* hdl/fca_controller.sv */
// Controller of the allocation table block: sequences each command and the
// clearing pass after reset. Depends on fca_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "fat_chain_allocator_top_assert.svh"

module fca_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  fca_pkg::fca_stat_type stat,
   output fca_pkg::fca_ctrl_type ctrl
);
   import fca_pkg::*;

   fca_state_type state_ff, state_in;
   logic          init_ff, init_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;

   // The output register can take a result when empty or being drained.
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.cmd)
               CMD_FORMAT: state_in = ST_FORMAT;
               CMD_ALLOC:  state_in = stat.count_zero ? ST_FINISH : ST_COUNT;
               CMD_FREE:   state_in = stat.start_is_data ? ST_FREE_WALK : ST_FINISH;
               CMD_READ:   state_in = stat.start_in_range ? ST_READ_WAIT : ST_FINISH;
               default:    state_in = ST_FINISH;
            endcase
         end
         ST_FORMAT: begin
            if (stat.fmt_last) begin
               state_in = init_ff ? ST_IDLE : ST_FINISH;
            end
         end
         ST_COUNT: begin
            if (stat.count_hit) begin
               state_in = ST_LINK;
            end else if (stat.scan_end) begin
               state_in = ST_FINISH;
            end
         end
         ST_LINK: begin
            if (stat.link_hit) begin
               state_in = ST_LINK_END;
            end
         end
         ST_LINK_END:  state_in = ST_FINISH;
         ST_FREE_WALK: begin
            if (!stat.walk_more) begin
               state_in = ST_FINISH;
            end
         end
         ST_READ_WAIT: state_in = ST_FINISH;
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands and handshake outputs.
   always_comb begin
      ctrl       = '0;
      req_tready = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            ctrl.load = req_tvalid;
         end
         ST_DECODE: begin
            case (stat.cmd)
               CMD_FORMAT: ctrl.fmt_init = 1'b1;
               CMD_ALLOC: begin
                  if (stat.count_zero) begin
                     ctrl.status_set  = 1'b1;
                     ctrl.status_code = STS_BAD_ARG;
                  end else begin
                     ctrl.data_init = 1'b1;
                  end
               end
               CMD_FREE: begin
                  if (stat.start_is_data) begin
                     ctrl.rd_start = 1'b1;
                  end else begin
                     ctrl.status_set  = 1'b1;
                     ctrl.status_code = STS_BAD_ARG;
                  end
               end
               CMD_READ: begin
                  if (stat.start_in_range) begin
                     ctrl.rd_start = 1'b1;
                  end else begin
                     ctrl.status_set  = 1'b1;
                     ctrl.status_code = STS_BAD_ARG;
                  end
               end
               default: ctrl.status_set = 1'b0;
            endcase
         end
         ST_FORMAT: begin
            ctrl.fmt_write = 1'b1;
         end
         ST_COUNT: begin
            ctrl.count_step = 1'b1;
            if (stat.count_hit) begin
               ctrl.data_init = 1'b1;
            end else if (stat.scan_end) begin
               ctrl.status_set  = 1'b1;
               ctrl.status_code = STS_NO_SPACE;
            end else begin
               ctrl.scan_issue = 1'b1;
            end
         end
         ST_LINK: begin
            ctrl.link_step  = 1'b1;
            ctrl.scan_issue = !stat.link_hit && !stat.scan_end;
         end
         ST_LINK_END: begin
            ctrl.end_write = 1'b1;
         end
         ST_FREE_WALK: begin
            ctrl.free_step = 1'b1;
         end
         ST_READ_WAIT: begin
            ctrl.entry_capture = 1'b1;
         end
         ST_FINISH: begin
            ctrl.res_load = slot_free;
         end
         default: ctrl = '0;
      endcase
   end

   // The clearing pass after reset produces no result.
   assign init_in      = (state_ff == ST_FORMAT && stat.fmt_last) ? 1'b0 : init_ff;
   assign rsp_valid_in = ctrl.res_load || (rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FORMAT;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FCA_ASSERT_NOW(a_load_slot_free, ctrl.res_load, !rsp_valid_ff || rsp_tready, "result loaded over a waiting item")
   `FCA_ASSERT_NEXT(a_accept_decode, req_tvalid && req_tready, state_ff == ST_DECODE, "accepted item not decoded")
   `FCA_ASSERT_NOW(a_idle_no_write, state_ff == ST_IDLE, !(ctrl.fmt_write || ctrl.link_step || ctrl.end_write || ctrl.free_step), "table written while idle")
   `FCA_ASSERT_NOW(a_sweep_quiet, init_ff, !ctrl.res_load && !req_tready, "clearing pass took an item or gave a result")

endmodule

/* hdl/fat_chain_allocator_top.sv */
// Block interface: configuration registers and stream channel packing.
// Usage:
//   Input items arrive on req_* (command in req_tuser), one result item per
//   command leaves on rsp_*. Items are handled one at a time; the block takes
//   a new item while the previous result still waits in the output register.
//   With n = min(blocks_in_use, NUM_BLOCKS): a read returns one table entry;
//     a format rewrites all NUM_BLOCKS entries; a free walks the chain; an
//     allocate makes up to two scans of the data blocks below n through
//     the table's single read port, one entry a cycle.
//   Bad arguments (zero count, index out of range) finish without a table access.
//   The next item can be taken in the cycle after a result enters the output register.
//   After reset the table is cleared by a pass over all NUM_BLOCKS entries that
//   marks blocks below 3 reserved; req_tready stays low meanwhile, while
//   register writes on csr_* are taken at all times.
//   If rsp_tready is held low, the finished result stays in the output
//   register and the next item waits in its last step until it is taken.
//   Registers: data_start at byte address 0, blocks_in_use at 4.
`timescale 1ns / 1ps

module fat_chain_allocator_top #(
   parameter int NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // Configuration port.
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [fca_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [fca_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [fca_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   // Input channel.
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [fca_pkg::REQ_DW-1:0]    req_tdata,  // block_count[10:0], start_block[20:11]
   input  logic [1:0]                    req_tuser,  // command[1:0]
   // Result channel.
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [fca_pkg::RSP_DW-1:0]    rsp_tdata   // status[1:0], first_block[11:2],
                                                     // entry_value[22:12], freed_count[33:23]
);
   import fca_pkg::*;

   logic [DS_W-1:0]            data_start_ff, data_start_in;
   logic [BIU_W-1:0]           blocks_in_use_ff, blocks_in_use_in;
   logic                       csr_wr;
   fca_reg_type                csr_reg;
   fca_ctrl_type               ctrl;
   fca_stat_type               stat;
   fca_status_type             rsp_status;
   logic [FIRST_W-1:0]         rsp_first_block;
   logic signed [ENT_OUT_W-1:0] rsp_entry_value;
   logic [FREED_W-1:0]         rsp_freed_count;

   // Register writes complete in the access cycle.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = fca_reg_type'(csr_paddr[2]);

   always_comb begin
      data_start_in    = data_start_ff;
      blocks_in_use_in = blocks_in_use_ff;
      csr_prdata       = '0;
      case (csr_reg)
         REG_DATA_START: begin
            csr_prdata = CSR_DW'(data_start_ff);
            if (csr_wr) begin
               data_start_in = csr_pwdata[DS_W-1:0];
            end
         end
         REG_BLOCKS_IN_USE: begin
            csr_prdata = CSR_DW'(blocks_in_use_ff);
            if (csr_wr) begin
               blocks_in_use_in = csr_pwdata[BIU_W-1:0];
            end
         end
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_start_ff    <= DS_RESET;
         blocks_in_use_ff <= BIU_RESET;
      end else begin
         data_start_ff    <= data_start_in;
         blocks_in_use_ff <= blocks_in_use_in;
      end
   end

   // Command sequencing.
   fca_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .ctrl       (ctrl)
   );

   // Table and result datapath.
   fca_datapath #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_command       (fca_cmd_type'(req_tuser)),
      .req_block_count   (req_tdata[CNT_W-1:0]),
      .req_start_block   (req_tdata[CNT_W+IDX_W-1:CNT_W]),
      .cfg_data_start    (data_start_ff),
      .cfg_blocks_in_use (blocks_in_use_ff),
      .ctrl              (ctrl),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_first_block   (rsp_first_block),
      .rsp_entry_value   (rsp_entry_value),
      .rsp_freed_count   (rsp_freed_count)
   );

   // Pack the result item, padded to whole bytes.
   assign rsp_tdata = {6'b0, rsp_freed_count, rsp_entry_value, rsp_first_block, rsp_status};

endmodule

/* verif/fat_chain_allocator_top_test.sv */
// Self-checking testbench for fat_chain_allocator_top: directed and random commands on the
// request stream, with every result item checked against an in-bench allocation table.
// Depends on fca_pkg and the fat_chain_allocator_top RTL only.
`timescale 1ns / 1ps

module fat_chain_allocator_top_test;
   import fca_pkg::*;

   localparam int NBLK        = NUM_BLOCKS_DEF;
   localparam int CYCLE_LIMIT = 5_000_000;

   typedef struct {
      fca_cmd_type cmd;
      logic [10:0] count;
      logic [9:0]  start;
   } fat_cmd_type;

   typedef struct {
      fca_status_type status;
      logic [9:0]     first;
      logic [10:0]    entry;
      logic [10:0]    freed;
   } fat_reply_type;

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [CSR_DW-1:0]   csr_pwdata  = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata   = '0;  // block_count[10:0], start_block[20:11]
   logic [1:0]          req_tuser   = '0;  // command[1:0]
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [RSP_DW-1:0]   rsp_tdata;         // status[1:0], first_block[11:2],
                                           // entry_value[22:12], freed_count[33:23]

   // Shadow of the block: allocation table and configuration.
   int fat [0:NBLK-1];
   int data_start_cfg = 3;
   int span_cfg       = 1024;

   fat_cmd_type   pending_cmds[$];
   fat_reply_type expected_replies[$];
   int            live_heads[$];
   int            errors     = 0;
   int            cycles     = 0;
   int            req_gap    = 0;
   int            rsp_stall  = 0;
   bit            steady     = 1'b0;

   fat_chain_allocator_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Blocks covered by the table: the smaller of the register and the table depth.
   function automatic int table_span();
      return (span_cfg < NBLK) ? span_cfg : NBLK;
   endfunction

   function automatic bit is_data_block(int v, int n);
      return v >= 0 && v >= data_start_cfg && v < n;
   endfunction

   function automatic int free_data_blocks();
      int n;
      int cnt;
      n = table_span();
      cnt = 0;
      for (int i = data_start_cfg; i < n; i++)
         if (fat[i] == ENTRY_FREE) cnt++;
      return cnt;
   endfunction

   function automatic void format_fat();
      for (int i = 0; i < NBLK; i++)
         fat[i] = (i < data_start_cfg) ? ENTRY_RESERVED : ENTRY_FREE;
   endfunction

   // Applies one command to the shadow table and returns the result it should produce.
   function automatic fat_reply_type apply_command(fat_cmd_type c);
      fat_reply_type r;
      int n;
      int taken;
      int prev;
      int blk;
      int nxt;
      int freed;
      r.status = STS_OK;
      r.first  = '0;
      r.entry  = '0;
      r.freed  = '0;
      n = table_span();
      case (c.cmd)
         CMD_FORMAT: begin
            format_fat();
         end
         CMD_ALLOC: begin
            if (c.count == 0) begin
               r.status = STS_BAD_ARG;
            end else if (free_data_blocks() < int'(c.count)) begin
               r.status = STS_NO_SPACE;
            end else begin
               taken = 0;
               prev = -1;
               for (int i = data_start_cfg; i < n && taken < int'(c.count); i++) begin
                  if (fat[i] == ENTRY_FREE) begin
                     if (prev < 0) r.first = 10'(i);
                     else fat[prev] = i;
                     prev = i;
                     taken++;
                  end
               end
               fat[prev] = ENTRY_END;
               live_heads = {live_heads, int'(r.first)};
            end
         end
         CMD_FREE: begin
            blk = int'(c.start);
            freed = 0;
            if (!is_data_block(blk, n)) begin
               r.status = STS_BAD_ARG;
            end else begin
               // Walk the chain until the link leaves the data area.
               while (is_data_block(blk, n) && freed < n) begin
                  nxt = fat[blk];
                  fat[blk] = ENTRY_FREE;
                  freed++;
                  blk = nxt;
               end
            end
            r.freed = 11'(freed);
         end
         default: begin
            if (int'(c.start) >= n) r.status = STS_BAD_ARG;
            else r.entry = 11'(fat[c.start]);
         end
      endcase
      return r;
   endfunction

   function automatic int draw_idle();
      if (steady || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 18);
   endfunction

   task automatic check_field(input string fname, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", fname, want, got);
         errors++;
      end
   endtask

   // Cycle limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Request driver: holds an item until taken, then waits its drawn gap.
   always @(posedge clock) begin : req_driver
      fat_cmd_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_tvalid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (pending_cmds.size() > 0) begin
            nxt = pending_cmds.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {3'b000, nxt.start, nxt.count};
            req_tuser <= nxt.cmd;
            req_gap <= draw_idle();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side flow control: a drawn stall after each result item.
   always @(posedge clock) begin : rsp_throttle
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall = draw_idle();
         rsp_tready <= (stall == 0);
         rsp_stall <= stall;
      end else if (rsp_stall > 0) begin
         rsp_tready <= (rsp_stall == 1);
         rsp_stall <= rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Checks results against the oldest prediction, then predicts any new item.
   always @(posedge clock) begin : scoreboard
      fat_reply_type got;
      fat_reply_type want;
      fat_cmd_type   c;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = fca_status_type'(rsp_tdata[1:0]);
            got.first  = rsp_tdata[11:2];
            got.entry  = rsp_tdata[22:12];
            got.freed  = rsp_tdata[33:23];
            if (expected_replies.size() == 0) begin
               $error("result item with no command outstanding");
               errors++;
            end else begin
               want = expected_replies.pop_front();
               check_field("status", int'(want.status), int'(got.status));
               check_field("first_block", int'(want.first), int'(got.first));
               check_field("entry_value", int'($signed(want.entry)), int'($signed(got.entry)));
               check_field("freed_count", int'(want.freed), int'(got.freed));
            end
         end
         if (req_tvalid && req_tready) begin
            c.cmd   = fca_cmd_type'(req_tuser);
            c.count = req_tdata[10:0];
            c.start = req_tdata[20:11];
            expected_replies = {expected_replies, apply_command(c)};
         end
      end
   end

   // Waits until every queued item has been taken, so the shadow table is current.
   task automatic wait_slot();
      while (pending_cmds.size() != 0 || req_tvalid) @(negedge clock);
   endtask

   task automatic issue(input fca_cmd_type cmd, input int count, input int start);
      fat_cmd_type c;
      wait_slot();
      c.cmd = cmd;
      c.count = 11'(count);
      c.start = 10'(start);
      pending_cmds = {pending_cmds, c};
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || req_tvalid || expected_replies.size() != 0)
         @(negedge clock);
   endtask

   // Register write followed by a read back of the same register.
   task automatic write_reg(input fca_reg_type r, input int value);
      logic [CSR_DW-1:0] got;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {r, 2'b00};
      csr_pwdata <= CSR_DW'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (r == REG_DATA_START) data_start_cfg = value;
      else span_cfg = value;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      got = csr_prdata;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      check_field(r == REG_DATA_START ? "data_start" : "blocks_in_use", value, int'(got));
   endtask

   // One random command, mostly well formed against the current table.
   task automatic issue_random();
      int n;
      int avail;
      int k;
      int sel;
      int cnt;
      int start;
      wait_slot();
      n = table_span();
      avail = free_data_blocks();
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, 9);
      start = $urandom_range(0, 1023);
      cnt = $urandom_range(0, 1024);
      if (sel < 5) begin
         issue(CMD_FORMAT, cnt, start);
      end else if (sel < 45) begin
         if (k <= 5) cnt = (avail > 0) ? $urandom_range(1, (avail < 8) ? avail : 8) : 1;
         else if (k == 6) cnt = avail;
         else if (k == 7) cnt = avail + 1;
         else if (k == 8) cnt = $urandom_range(0, 1) ? 1024 : 0;
         issue(CMD_ALLOC, cnt, start);
      end else if (sel < 75) begin
         if (k < 6 && live_heads.size() > 0) begin
            k = $urandom_range(0, live_heads.size() - 1);
            start = live_heads[k];
            live_heads.delete(k);
         end else if (k < 8 && data_start_cfg < n) begin
            start = $urandom_range(data_start_cfg, n - 1);
         end
         issue(CMD_FREE, cnt, start);
      end else begin
         if (k < 7) start = $urandom_range(0, n - 1);
         issue(CMD_READ, cnt, start);
      end
   endtask

   initial begin : stimulus
      int ds_set   [8];
      int span_set [8];
      int item_set [8];
      ds_set   = '{3, 1, 1023, 5, 100, 17, 2, 1};
      span_set = '{1024, 2, 1024, 64, 50, 200, 1024, 37};
      item_set = '{60, 40, 40, 120, 30, 120, 60, 90};
      format_fat();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // The table clearing pass after reset holds off the request channel.
      @(negedge clock);
      while (!req_tready) @(negedge clock);

      // Directed commands on the reset configuration.
      issue(CMD_READ, 0, 0);
      issue(CMD_READ, 0, 1023);
      issue(CMD_ALLOC, 0, 0);
      issue(CMD_ALLOC, 1, 0);
      issue(CMD_ALLOC, 5, 0);
      issue(CMD_READ, 0, 4);
      issue(CMD_READ, 0, 8);
      issue(CMD_FREE, 0, 0);
      issue(CMD_FREE, 2047, 1023);
      issue(CMD_FREE, 0, 4);
      issue(CMD_ALLOC, 1024, 0);
      wait_slot();
      issue(CMD_ALLOC, free_data_blocks(), 1023);
      issue(CMD_READ, 0, 1023);
      issue(CMD_READ, 0, 500);
      issue(CMD_FREE, 0, 4);
      issue(CMD_FORMAT, 2047, 1023);
      issue(CMD_ALLOC, 1024, 0);
      issue(CMD_FREE, 0, 3);
      issue(CMD_READ, 0, 2);
      issue(CMD_ALLOC, 7, 0);
      issue(CMD_FREE, 0, 3);

      // Random phases over a range of register settings, the extremes among them.
      for (int p = 0; p < 8; p++) begin
         wait_drained();
         if (p > 0) begin
            write_reg(REG_DATA_START, ds_set[p]);
            write_reg(REG_BLOCKS_IN_USE, span_set[p]);
            @(negedge clock);
         end
         steady = (p == 3 || p == 7);
         if (p == 4) issue(CMD_READ, 0, 100);
         for (int i = 0; i < item_set[p]; i++) issue_random();
      end

      wait_drained();
      steady = 1'b0;
      repeat (20) @(posedge clock);
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
